// File: hdl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the text console engine
// Request codes, item structs, controller states and default geometry.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int TCE_COLUMNS  = 80;
  localparam int TCE_ROWS     = 25;
  localparam int TCE_TAB_STOP = 8;

  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COLOR_W   = 4;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  typedef enum logic [1:0] {
    REQ_PRINT = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR = 1'b0,
    CFG_BG_COLOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SWEEP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_x;
    logic [4:0]  cursor_y;
    logic [10:0] cursor_addr;
    logic        scrolled;
  } out_item_t;

endpackage

// File: hdl/tce_ram.sv
// ----------------------------------------------------------------------------
// tce_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/text_console_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_engine_core: character terminal with scrolling
// Keeps a cell store, a cursor and a top-row offset; prints, moves the
// cursor, clears the screen and reads cells.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one request. Output
//   channel out_valid/out_stall/out_item returns one result per request.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data sets the fg and bg
//   color nibbles; cfg_ready is always high. Write it only when idle.
// Sequence: an accepted request enters the execute state and ends in the
//   output state, where the result is loaded into the output register.
//   read cell: a read state between them takes the registered RAM data.
//   print that scrolls: a sweep state writes one row of blanks.
//   clear: the sweep state writes every cell, one cell written a cycle.
//   One item at a time; in_stall drops in the same cycle as the result is
//   registered, so a new item is not taken before the last one is done.
// Reset (rst, synchronous): cursor and top-row offset go to 0, colors to
//   fg 7 / bg 0. Cell contents are undefined until written.
// A stalled result holds in the output register; the block then waits in
//   its output state and takes no new item until the result is loaded.
// ----------------------------------------------------------------------------
module text_console_engine_core
  import tce_pkg::*;
#(
  parameter int COLUMNS  = TCE_COLUMNS,
  parameter int ROWS     = TCE_ROWS,
  parameter int TAB_STOP = TCE_TAB_STOP
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS << CW;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (RW + 8 > 11) ? RW + 8 : 11;

  state_t state, state_next;

  in_item_t              rq;
  logic [CW-1:0]         cursor_col;
  logic [RW-1:0]         cursor_row;
  logic [RW-1:0]         top;
  logic [COLOR_W-1:0]    fg_color;
  logic [COLOR_W-1:0]    bg_color;
  logic [CELL_W-1:0]     data_q;
  logic                  scrolled_q;
  logic [RW-1:0]         sweep_row;
  logic [CW-1:0]         sweep_col;
  logic                  sweep_all;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [CELL_W-1:0]     ram_wdata;
  logic [CELL_W-1:0]     ram_rdata;

  logic [CELL_W-1:0]     blank_cell;
  logic [CW+1:0]         px;
  logic [RW:0]           py;
  logic                  p_we;
  logic [CW-1:0]         p_wcol;
  logic [7:0]            p_char;
  logic                  p_scroll;
  logic [CW-1:0]         p_col;
  logic [RW-1:0]         p_row;
  logic                  rd_in_range;
  logic                  sweep_done;
  logic                  out_load;
  logic [LW-1:0]         lin_addr;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  tce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign blank_cell  = {bg_color, fg_color, CH_BLANK};
  assign cfg_ready   = 1'b1;
  assign rd_in_range = (int'(rq.col) < COLUMNS) && (int'(rq.row) < ROWS);
  assign sweep_done  = (sweep_col == CW'(COLUMNS - 1)) &&
                       (!sweep_all || sweep_row == RW'(ROWS - 1));

  // print: cursor advance, wrap and scroll
  always_comb begin
    int tb;
    tb     = 0;
    px     = {2'b00, cursor_col};
    py     = {1'b0, cursor_row};
    p_we   = 1'b0;
    p_wcol = cursor_col;
    p_char = rq.char_code;
    for (int k = 1; k <= COLUMNS; k++) begin
      if (k * TAB_STOP <= int'(cursor_col)) begin
        tb = k * TAB_STOP;
      end
    end
    if (rq.char_code == CH_CR || rq.char_code == CH_LF) begin
      px = '0;
      py = py + 1'b1;
    end else if (rq.char_code == CH_TAB) begin
      px = (CW+2)'(tb + TAB_STOP);
    end else if (rq.char_code == CH_BACKSPACE) begin
      if (cursor_col != '0) begin
        px     = {2'b00, cursor_col - 1'b1};
        p_we   = 1'b1;
        p_wcol = cursor_col - 1'b1;
        p_char = CH_BLANK;
      end
    end else begin
      px   = {2'b00, cursor_col} + 1'b1;
      p_we = 1'b1;
    end
    // a tab can overshoot by more than one line width on narrow screens
    if (px >= (CW+2)'(COLUMNS)) begin
      px = px - (CW+2)'(COLUMNS);
      py = py + 1'b1;
      if (px >= (CW+2)'(COLUMNS)) begin
        px = px - (CW+2)'(COLUMNS);
      end
    end
    p_scroll = (py >= (RW+1)'(ROWS));
    p_col    = px[CW-1:0];
    p_row    = p_scroll ? RW'(ROWS - 1) : py[RW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (req_t'(rq.req_type))
          REQ_PRINT: state_next = p_scroll ? S_SWEEP : S_OUT;
          REQ_SET:   state_next = S_OUT;
          REQ_CLEAR: state_next = S_SWEEP;
          REQ_READ:  state_next = rd_in_range ? S_READ : S_OUT;
          default:   state_next = S_OUT;
        endcase
      end
      S_READ:  state_next = S_OUT;
      S_SWEEP: begin
        if (sweep_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_load  = (state == S_OUT) && (!out_valid || !out_stall);
    ram_we    = 1'b0;
    ram_addr  = {sweep_row, sweep_col};
    ram_wdata = blank_cell;
    unique case (state)
      S_EXEC: begin
        if (rq.req_type == REQ_PRINT) begin
          ram_we    = p_we;
          ram_addr  = {phys_row(cursor_row, top), p_wcol};
          ram_wdata = {bg_color, fg_color, p_char};
        end else begin
          ram_addr = {phys_row(rq.row[RW-1:0], top), rq.col[CW-1:0]};
        end
      end
      S_SWEEP: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  assign lin_addr = LW'(cursor_row) * LW'(COLUMNS) + LW'(cursor_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      top        <= '0;
      fg_color   <= COLOR_W'(7);
      bg_color   <= '0;
      out_valid  <= 1'b0;
      sweep_all  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FG_COLOR) fg_color <= cfg_data;
        if (cfg_index == CFG_BG_COLOR) bg_color <= cfg_data;
      end
      if (state == S_EXEC) begin
        unique case (req_t'(rq.req_type))
          REQ_PRINT: begin
            cursor_col <= p_col;
            cursor_row <= p_row;
            if (p_scroll) begin
              // old top row becomes the new bottom row
              top       <= (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
              sweep_all <= 1'b0;
            end
          end
          REQ_SET: begin
            cursor_col <= (rq.col >= 8'(COLUMNS)) ? CW'(COLUMNS - 1) : rq.col[CW-1:0];
            cursor_row <= (rq.row >= 8'(ROWS)) ? RW'(ROWS - 1) : rq.row[RW-1:0];
          end
          REQ_CLEAR: begin
            cursor_col <= '0;
            cursor_row <= '0;
            top        <= '0;
            sweep_all  <= 1'b1;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      rq <= in_item;
    end
    if (state == S_EXEC) begin
      data_q     <= '0;
      scrolled_q <= (rq.req_type == REQ_PRINT) && p_scroll;
      sweep_col  <= '0;
      sweep_row  <= (rq.req_type == REQ_CLEAR) ? '0 : top;
    end
    if (state == S_READ) begin
      data_q <= ram_rdata;
    end
    if (state == S_SWEEP) begin
      if (sweep_col == CW'(COLUMNS - 1)) begin
        sweep_col <= '0;
        sweep_row <= sweep_row + 1'b1;
      end else begin
        sweep_col <= sweep_col + 1'b1;
      end
    end
    if (out_load) begin
      out_item.cell_data   <= data_q;
      out_item.cursor_x    <= 7'(cursor_col);
      out_item.cursor_y    <= 5'(cursor_row);
      out_item.cursor_addr <= lin_addr[10:0];
      out_item.scrolled    <= scrolled_q;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    int'(cursor_col) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    int'(cursor_row) < ROWS && int'(top) < ROWS)
    else $error("cursor row or top offset out of range");

  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(state) == S_EXEC)
    else $error("cell read data taken without a read issued");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && sweep_done) |=> state == S_OUT)
    else $error("sweep did not finish");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == S_OUT && !ram_we))
    else $error("result loaded while cells are being written");

endmodule

// File: sim/text_console_checker.sv
// ----------------------------------------------------------------------------
// text_console_checker: request/result checker for the text console engine
// Follows the config and request channels, keeps its own copy of the screen,
// cursor, scroll offset and colors, and compares every result item with the
// oldest predicted one. Counts mismatches and reports results still owed.
// ----------------------------------------------------------------------------
module text_console_checker
  import tce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int                   mismatch_count,
  output int                   replies_due
);

  localparam int COLS  = TCE_COLUMNS;
  localparam int LINES = TCE_ROWS;

  logic [CELL_W-1:0]  screen [0:COLS*LINES-1];
  int                 cur_col;
  int                 cur_row;
  int                 top_line;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  out_item_t          console_replies [$];

  function automatic int cell_index(int c, int r);
    return ((r + top_line) % LINES) * COLS + (c % COLS);
  endfunction

  function automatic logic [CELL_W-1:0] paint(logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

  // Applies one request to the screen copy and returns the cursor report.
  function automatic out_item_t console_step(in_item_t req);
    int          x;
    int          y;
    logic [15:0] data;
    logic        scr;
    out_item_t   rep;
    x    = cur_col;
    y    = cur_row;
    data = '0;
    scr  = 1'b0;
    case (req_t'(req.req_type))
      REQ_PRINT: begin
        if (req.char_code == CH_CR || req.char_code == CH_LF) begin
          x = 0;
          y++;
        end else if (req.char_code == CH_TAB) begin
          x += TCE_TAB_STOP - x % TCE_TAB_STOP;
        end else if (req.char_code == CH_BACKSPACE) begin
          if (x > 0) begin
            x--;
            screen[cell_index(x, y)] = paint(CH_BLANK);
          end
        end else begin
          screen[cell_index(x, y)] = paint(req.char_code);
          x++;
        end
        if (x >= COLS) begin
          x = x % COLS;
          y++;
        end
        // bottom overflow: offset moves first, then the new bottom line blanks
        if (y >= LINES) begin
          y        = LINES - 1;
          top_line = (top_line + 1) % LINES;
          for (int c = 0; c < COLS; c++) screen[cell_index(c, LINES - 1)] = paint(CH_BLANK);
          scr = 1'b1;
        end
        cur_col = x;
        cur_row = y;
      end
      REQ_SET: begin
        cur_col = (req.col >= COLS) ? COLS - 1 : req.col;
        cur_row = (req.row >= LINES) ? LINES - 1 : req.row;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < COLS * LINES; i++) screen[i] = paint(CH_BLANK);
        top_line = 0;
        cur_col  = 0;
        cur_row  = 0;
      end
      default: begin
        if (req.col < COLS && req.row < LINES) data = screen[cell_index(req.col, req.row)];
      end
    endcase
    rep.cell_data   = data;
    rep.cursor_x    = 7'(cur_col);
    rep.cursor_y    = 5'(cur_row);
    rep.cursor_addr = 11'(cur_row * COLS + cur_col);
    rep.scrolled    = scr;
    return rep;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cur_col  = 0;
      cur_row  = 0;
      top_line = 0;
      fg       = 4'd7;
      bg       = 4'd0;
      console_replies.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FG_COLOR) fg = cfg_data;
        else if (cfg_index == CFG_BG_COLOR) bg = cfg_data;
      end
      if (in_valid && !in_stall) console_replies.push_back(console_step(in_item));
      if (out_valid && !out_stall) begin
        if (console_replies.size() == 0) begin
          $error("result item with no request outstanding: 0x%0h", out_item);
          mismatch_count++;
        end else begin
          want = console_replies.pop_front();
          compare_field("cell_data", want.cell_data, out_item.cell_data);
          compare_field("cursor_x", want.cursor_x, out_item.cursor_x);
          compare_field("cursor_y", want.cursor_y, out_item.cursor_y);
          compare_field("cursor_addr", want.cursor_addr, out_item.cursor_addr);
          compare_field("scrolled", want.scrolled, out_item.scrolled);
        end
      end
    end
    replies_due = console_replies.size();
  end

endmodule

// File: sim/tb_text_console_engine_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_engine_core: testbench of the text console engine
// Directed requests for wrap, scroll, tab, backspace, clamping and reads,
// then random print-heavy traffic over several color settings, with bursty
// input and a patterned output stall. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_text_console_engine_core;
  import tce_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 100;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;
  int                   mismatch_count;
  int                   replies_due;
  int                   burst_left  = 0;
  int                   cycle_count = 0;
  int                   stall_mode  = 0;
  int                   mode_left   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  text_console_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** text_console_engine_core: FAILED **");
      $finish;
    end
  end

  // result side: the stall mode changes whenever its random countdown runs out
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= cycle_count[2];
    endcase
  end

  function automatic in_item_t make_req(req_t kind, logic [7:0] ch, logic [7:0] c,
                                        logic [7:0] r);
    in_item_t req;
    req.req_type  = kind;
    req.char_code = ch;
    req.col       = c;
    req.row       = r;
    return req;
  endfunction

  // mostly prints; cursor moves favor the bottom lines so scrolls happen often
  function automatic in_item_t random_request();
    int         pick;
    logic [7:0] ch;
    logic [7:0] c;
    logic [7:0] r;
    req_t       kind;
    pick = $urandom_range(0, 99);
    ch   = $urandom_range(0, 255);
    c    = $urandom_range(0, 255);
    r    = $urandom_range(0, 255);
    if (pick < 66) begin
      kind = REQ_PRINT;
      case ($urandom_range(0, 9))
        0:       ch = CH_CR;
        1:       ch = CH_LF;
        2:       ch = CH_TAB;
        3:       ch = CH_BACKSPACE;
        4:       ;
        default: ch = $urandom_range(8'h20, 8'h7E);
      endcase
    end else if (pick < 80) begin
      kind = REQ_SET;
      if ($urandom_range(0, 4) != 0) begin
        c = $urandom_range(0, TCE_COLUMNS - 1);
        r = $urandom_range(0, 1) ? $urandom_range(TCE_ROWS - 4, TCE_ROWS - 1)
                                 : $urandom_range(0, TCE_ROWS - 1);
      end
    end else if (pick < 98) begin
      kind = REQ_READ;
      if ($urandom_range(0, 5) != 0) begin
        c = $urandom_range(0, TCE_COLUMNS - 1);
        r = $urandom_range(0, 1) ? $urandom_range(TCE_ROWS - 4, TCE_ROWS - 1)
                                 : $urandom_range(0, TCE_ROWS - 1);
      end
    end else begin
      kind = REQ_CLEAR;
    end
    return make_req(kind, ch, c, r);
  endfunction

  task automatic send_request(in_item_t req);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (replies_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_color(cfg_reg_t idx, logic [COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [COLOR_W-1:0] fg_set [PHASES];
    logic [COLOR_W-1:0] bg_set [PHASES];
    fg_set = '{4'hF, 4'h0, 4'h0, 4'hF, 4'h7, 4'h7};
    bg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
    fg_set[5] = $urandom_range(0, 15);
    bg_set[5] = $urandom_range(0, 15);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      write_color(CFG_FG_COLOR, fg_set[p]);
      write_color(CFG_BG_COLOR, bg_set[p]);
      if (p == 0) begin
        // clear first: every cell is written before any read
        send_request(make_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00));
        send_request(make_req(REQ_PRINT, 8'h41, 8'hFF, 8'hFF));
        send_request(make_req(REQ_PRINT, 8'hFF, 8'h00, 8'h00));
        send_request(make_req(REQ_PRINT, 8'h00, 8'h00, 8'h00));
        send_request(make_req(REQ_READ, 8'h00, 8'd0, 8'd0));
        send_request(make_req(REQ_PRINT, CH_TAB, 8'h00, 8'h00));
        send_request(make_req(REQ_PRINT, CH_BACKSPACE, 8'h00, 8'h00));
        send_request(make_req(REQ_READ, 8'h00, 8'd7, 8'd0));
        send_request(make_req(REQ_PRINT, CH_CR, 8'h00, 8'h00));
        send_request(make_req(REQ_PRINT, CH_BACKSPACE, 8'h00, 8'h00));
        send_request(make_req(REQ_PRINT, CH_LF, 8'h00, 8'h00));
        send_request(make_req(REQ_SET, 8'h00, 8'hFF, 8'hFF));
        send_request(make_req(REQ_PRINT, 8'h5A, 8'h00, 8'h00));
        send_request(make_req(REQ_READ, 8'h00, 8'd79, 8'd23));
        send_request(make_req(REQ_READ, 8'h00, 8'd80, 8'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'd0, 8'd25));
        send_request(make_req(REQ_READ, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(REQ_SET, 8'h00, 8'd77, 8'd24));
        send_request(make_req(REQ_PRINT, CH_TAB, 8'h00, 8'h00));
        send_request(make_req(REQ_SET, 8'h00, 8'd0, 8'd24));
        send_request(make_req(REQ_PRINT, CH_LF, 8'h00, 8'h00));
        send_request(make_req(REQ_SET, 8'h00, 8'd0, 8'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'd79, 8'd24));
        send_request(make_req(REQ_SET, 8'h00, 8'd79, 8'd0));
        send_request(make_req(REQ_PRINT, 8'h7E, 8'h00, 8'h00));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
      drain();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("** text_console_engine_core: PASSED **");
    end else begin
      $display("** text_console_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
